// File: src/sbfc_pkg.sv
// Shared constants and types for the sync-byte frame checksum receiver.
package sbfc_pkg;

  localparam int unsigned FrameLen = 7;
  localparam int unsigned StoreDepth = FrameLen - 1;
  localparam int unsigned IdxW = 3;

  localparam logic [7:0] SYNC_ADDR  = 8'hFA;
  localparam logic [7:0] SYNC_ALT   = 8'hF5;
  localparam logic [7:0] SYNC_BLOCK = 8'hFC;

  typedef enum logic {
    REG_TYPE_CODE   = 1'b0,
    REG_UNIT_NUMBER = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [FrameLen-1:0][7:0] frame;
    logic                     checksum_good;
    logic                     for_this_unit;
  } sbfc_result_t;

  function automatic logic is_sync(input logic [7:0] b);
    is_sync = (b == SYNC_ADDR) || (b == SYNC_ALT) || (b == SYNC_BLOCK);
  endfunction

endpackage

// File: src/sbfc_framer.sv
// Sync hunt, frame capture, running sum and result flags for one byte per cycle while step is high.
module sbfc_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          type_code,
  input  logic [7:0]          unit_number,
  output logic                res_valid,
  output sbfc_pkg::sbfc_result_t res
);
  import sbfc_pkg::*;

  logic                         in_frame, in_frame_next;
  logic [IdxW-1:0]              byte_index, byte_index_next;
  logic [7:0]                   running_sum, running_sum_next;
  logic [StoreDepth-1:0][7:0]   frame_store;

  logic                         active;
  logic [IdxW-1:0]              idx_eff;
  logic [7:0]                   sum_eff;
  logic                         last_byte;
  logic [7:0]                   sum_total;

  always_comb begin
    active    = step && (in_frame || is_sync(rx_byte));
    idx_eff   = in_frame ? byte_index : '0;
    sum_eff   = in_frame ? running_sum : '0;
    last_byte = idx_eff >= IdxW'(StoreDepth);
    sum_total = sum_eff + rx_byte;

    in_frame_next    = in_frame;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    res_valid        = 1'b0;

    if (active) begin
      if (last_byte) begin
        in_frame_next    = 1'b0;
        byte_index_next  = '0;
        running_sum_next = '0;
        res_valid        = 1'b1;
      end else begin
        in_frame_next    = 1'b1;
        byte_index_next  = idx_eff + 1'b1;
        running_sum_next = sum_total;
      end
    end

    for (int k = 0; k < StoreDepth; k++) begin
      res.frame[k] = frame_store[k];
    end
    res.frame[FrameLen-1] = rx_byte;
    res.checksum_good     = (sum_total == 8'h00);
    res.for_this_unit     = (frame_store[0] == SYNC_ADDR) &&
                            (frame_store[1] == type_code) &&
                            (frame_store[2] == unit_number);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_index  <= '0;
      running_sum <= '0;
    end else begin
      in_frame    <= in_frame_next;
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (active && !last_byte) begin
      for (int k = 0; k < StoreDepth; k++) begin
        if (idx_eff == IdxW'(k)) begin
          frame_store[k] <= rx_byte;
        end
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IdxW'(StoreDepth))
    else $error("byte index past end of frame");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (byte_index == '0) && (running_sum == 8'h00))
    else $error("hunt state with stale index or sum");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !in_frame)
    else $error("frame not closed after result");

  a_result_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_frame && (byte_index == IdxW'(StoreDepth)))
    else $error("result outside last frame position");

endmodule

// File: src/sync_byte_frame_checksum_receiver.sv
// Top level: byte stream in, frame results out, register port for the address match.
// A byte is registered at its transfer and processed when the output advances; a
// frame's result is then registered to the output as its seventh byte is processed.
// Throughput: one byte per cycle unless stalled; sum and compare are combinational.
// A stalled output holds the input register, which then stalls the input side.
// Reset clears the hunt state, index, sum, valid flags and both match registers;
// the frame store is not reset.
module sync_byte_frame_checksum_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] frame_b0 .. [55:48] frame_b6
  output logic [1:0]  m_tuser,   // [0] checksum_good, [1] for_this_unit
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbfc_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         advance;
  logic [7:0]   type_code;
  logic [7:0]   unit_number;
  logic         res_valid;
  sbfc_result_t res;
  sbfc_result_t out_res;
  reg_idx_t     reg_sel;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign pready   = 1'b1;
  assign reg_sel  = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  sbfc_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .step        (in_valid && advance),
    .rx_byte     (in_byte),
    .type_code   (type_code),
    .unit_number (unit_number),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = out_res.frame;
  assign m_tuser = {out_res.for_this_unit, out_res.checksum_good};

  always_ff @(posedge clk) begin
    if (rst) begin
      type_code   <= '0;
      unit_number <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_TYPE_CODE:   type_code   <= pwdata[7:0];
        REG_UNIT_NUMBER: unit_number <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TYPE_CODE:   prdata = {24'd0, type_code};
      REG_UNIT_NUMBER: prdata = {24'd0, unit_number};
      default:         prdata = '0;
    endcase
  end

endmodule
